// ===== sv/jrsv_pkg.sv =====
package jrsv_pkg;

   // default container nesting limit
   localparam int MAX_NEST_DEF = 32;
   // transaction queue between parser and result sequencer
   localparam int Q_DEPTH = 4;
   localparam int OP_LEN = 23;
   // largest int64 magnitude that may still take another digit
   localparam logic [63:0] PID_STEP_LIMIT = 64'd922337203685477580;
   localparam logic [63:0] PID_MAX = 64'h0000_0000_7fff_ffff;

   typedef enum logic [4:0] {
      P_START, P_TOP_FIRST, P_TOP_KEY, P_TOP_COLON, P_TOP_VALUE, P_TOP_AFTER,
      P_DONE, P_STR, P_ESC, P_HEX, P_BSL, P_U, P_HEXLO, P_VAL, P_LIT0, P_LIT1,
      P_LIT2, P_NSIGN, P_NZERO, P_NDIG, P_FRAC1, P_FRAC, P_EXPS, P_EXP1, P_EXP,
      P_OOPEN, P_AOPEN, P_SAFTER, P_SKEY, P_SCOLON
   } phase_type;

   typedef enum logic [2:0] {
      R_KEY, R_OP, R_HINT, R_SKIPV, R_SKIPK, R_PID, R_NUM
   } role_type;

   typedef enum logic [1:0] {
      ST_OK, ST_INVALID, ST_UNSUPPORTED, ST_BAD_PID
   } status_type;

   // one queue entry: up to four hint bytes and an optional verdict
   typedef struct packed {
      logic [2:0]  cnt;
      logic [31:0] bytes;
      logic        verdict;
      status_type  status;
      logic [30:0] pid;
   } qentry_type;

   typedef struct packed {
      logic [2:0]  n;
      logic [31:0] bytes;
   } utf8_type;

   localparam logic [71:0]  KEY_OP_TEXT = {"op", 56'd0};
   localparam logic [71:0]  KEY_PID_TEXT = {"pid", 48'd0};
   localparam logic [71:0]  KEY_HINT_TEXT = "titleHint";
   localparam logic [183:0] OP_TEXT = "getCurrentWindowDisplay";
   localparam logic [39:0]  LIT_TRUE = {"true", 8'd0};
   localparam logic [39:0]  LIT_FALSE = "false";
   localparam logic [39:0]  LIT_NULL = {"null", 8'd0};

   function automatic logic is_ws(logic [7:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   // hex digit value, bit 4 set when the byte is a hex digit
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c inside {["0":"9"]}) begin
         t = c - "0";
         return {1'b1, t[3:0]};
      end else if (c inside {["a":"f"]}) begin
         t = c - "a" + 8'd10;
         return {1'b1, t[3:0]};
      end else if (c inside {["A":"F"]}) begin
         t = c - "A" + 8'd10;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [3:0] key_len(int j);
      case (j)
         0: return 4'd2;
         1: return 4'd3;
         default: return 4'd9;
      endcase
   endfunction

   function automatic logic key_match(int j, logic [3:0] pos, logic [7:0] ch);
      logic [71:0] txt;
      case (j)
         0: txt = KEY_OP_TEXT;
         1: txt = KEY_PID_TEXT;
         default: txt = KEY_HINT_TEXT;
      endcase
      if (pos >= key_len(j)) return 1'b0;
      return txt[71 - 8*pos -: 8] == ch;
   endfunction

   function automatic logic op_match(logic [4:0] pos, logic [7:0] ch);
      if (pos >= 5'(OP_LEN)) return 1'b0;
      return OP_TEXT[183 - 8*pos -: 8] == ch;
   endfunction

   function automatic logic [2:0] lit_len(logic [1:0] i);
      return (i == 2'd1) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic lit_match(logic [1:0] i, logic [2:0] pos, logic [7:0] ch);
      logic [39:0] txt;
      case (i)
         2'd0: txt = LIT_TRUE;
         2'd1: txt = LIT_FALSE;
         default: txt = LIT_NULL;
      endcase
      if (pos >= lit_len(i)) return 1'b0;
      return txt[39 - 8*pos -: 8] == ch;
   endfunction

   // code point to utf-8, first byte in the low lane
   function automatic utf8_type utf8_encode(logic [20:0] cp);
      utf8_type u;
      u.bytes = 32'd0;
      if (cp <= 21'h7f) begin
         u.n = 3'd1;
         u.bytes[7:0] = cp[7:0];
      end else if (cp <= 21'h7ff) begin
         u.n = 3'd2;
         u.bytes[7:0] = {3'b110, cp[10:6]};
         u.bytes[15:8] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
         u.n = 3'd3;
         u.bytes[7:0] = {4'b1110, cp[15:12]};
         u.bytes[15:8] = {2'b10, cp[11:6]};
         u.bytes[23:16] = {2'b10, cp[5:0]};
      end else begin
         u.n = 3'd4;
         u.bytes[7:0] = {5'b11110, cp[20:18]};
         u.bytes[15:8] = {2'b10, cp[17:12]};
         u.bytes[23:16] = {2'b10, cp[11:6]};
         u.bytes[31:24] = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

endpackage

// ===== sv/jrsv_req_if.sv =====
interface jrsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_final;

   modport source (output valid, output in_byte, output is_final, input ready);
   modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

// ===== sv/jrsv_rsp_if.sv =====
interface jrsv_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  hint_byte;
   logic [1:0]  status;
   logic [30:0] pid_value;
   logic        run_end;

   modport source (output valid, output kind, output hint_byte, output status,
                   output pid_value, output run_end, input ready);
   modport sink (input valid, input kind, input hint_byte, input status,
                 input pid_value, input run_end, output ready);
endinterface

// ===== sv/json_request_stream_validator.sv =====
// JSON request line validator.
// req_bus carries one raw byte of the request line per transaction, with
// is_final marking the last byte. rsp_bus carries results: decoded titleHint
// bytes (kind 0) as they are decoded, then one verdict (kind 1) with status
// and pid after the final byte. run_end marks the last result of an input byte.
// The parser takes one byte per cycle while the queue is not full; a byte's
// results are written into a four-entry queue when the byte is accepted and
// leave the queue head on rsp_bus, one result per cycle while rsp_bus.ready is
// high. A byte with no result writes nothing; one with n results holds the
// sequencer until all n are taken, so the sustained rate is one byte per cycle
// as long as results average at most one per byte. Backpressure on rsp_bus
// fills the queue; req_bus.ready drops only when the queue is full.
// Synchronous reset returns the parser to expecting an opening brace and
// empties the queue. After a final byte the parser also returns to that state.
module json_request_stream_validator #(
   parameter int MAX_NEST = jrsv_pkg::MAX_NEST_DEF
) (
   input logic        clock,
   input logic        reset,
   jrsv_req_if.sink   req_bus,
   jrsv_rsp_if.source rsp_bus
);
   import jrsv_pkg::*;

   qentry_type push_entry, head_entry;
   logic       push_valid, push_ready, head_valid, pop;

   jrsv_front #(.MAX_NEST(MAX_NEST)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   jrsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   jrsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== sv/jrsv_front.sv =====
module jrsv_front #(
   parameter int MAX_NEST = jrsv_pkg::MAX_NEST_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   jrsv_req_if.sink             req_bus,
   output logic                 push_valid,
   input  logic                 push_ready,
   output jrsv_pkg::qentry_type push_entry
);
   import jrsv_pkg::*;

   localparam int LW = $clog2(MAX_NEST + 2);

   typedef struct packed {
      phase_type         phase;
      logic [LW-1:0]     level;
      logic [MAX_NEST:0] stack;
      logic [2:0]        fields;
      logic              failed;
      logic [2:0]        cand;
      logic [3:0]        kpos;
      logic [4:0]        npos;
      logic              nmatch;
      logic [15:0]       hex;
      logic [9:0]        hsur;
      logic [2:0]        tpos;
      logic [63:0]       mag;
      logic [1:0]        pflags;
      role_type          role;
   } pstate_type;

   typedef struct packed {
      pstate_type  s;
      logic        redo;
      logic [2:0]  cnt;
      logic [31:0] bytes;
   } step_type;

   function automatic pstate_type reset_state();
      pstate_type s;
      s = '0;
      s.phase = P_START;
      s.role = R_KEY;
      return s;
   endfunction

   // route decoded string bytes to key matcher, op matcher or hint output
   function automatic step_type do_sink(step_type r, logic [2:0] n, logic [31:0] b);
      logic [7:0] ch;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < n) begin
            ch = b[8*k +: 8];
            case (r.s.role)
               R_KEY: begin
                  for (int j = 0; j < 3; j++)
                     if (!key_match(j, r.s.kpos, ch)) r.s.cand[j] = 1'b0;
                  if (r.s.kpos != 4'd15) r.s.kpos = r.s.kpos + 4'd1;
               end
               R_OP: begin
                  if (!op_match(r.s.npos, ch)) r.s.nmatch = 1'b0;
                  if (r.s.npos != 5'd31) r.s.npos = r.s.npos + 5'd1;
               end
               R_HINT: begin
                  r.bytes[8*r.cnt[1:0] +: 8] = ch;
                  r.cnt = r.cnt + 3'd1;
               end
               default: ;
            endcase
         end
      end
      return r;
   endfunction

   function automatic step_type do_emit(step_type r, logic [20:0] cp);
      utf8_type u;
      u = utf8_encode(cp);
      return do_sink(r, u.n, u.bytes);
   endfunction

   function automatic pstate_type value_end(pstate_type s);
      s.phase = (s.level == '0) ? P_TOP_AFTER : P_SAFTER;
      return s;
   endfunction

   function automatic pstate_type push(pstate_type s, logic kind, phase_type nxt);
      if (s.level > LW'(MAX_NEST)) begin
         s.failed = 1'b1;
      end else begin
         s.stack = {s.stack[MAX_NEST-1:0], kind};
         s.level = s.level + 1'b1;
         s.phase = nxt;
      end
      return s;
   endfunction

   function automatic pstate_type pop_end(pstate_type s);
      if (s.level != '0) s.level = s.level - 1'b1;
      s.stack = {1'b0, s.stack[MAX_NEST:1]};
      return value_end(s);
   endfunction

   function automatic pstate_type open_string(pstate_type s, role_type r);
      s.role = r;
      s.phase = P_STR;
      if (r == R_KEY) begin
         s.cand = 3'b111;
         s.kpos = 4'd0;
      end
      if (r == R_OP) begin
         s.nmatch = 1'b1;
         s.npos = 5'd0;
      end
      return s;
   endfunction

   function automatic pstate_type close_string(pstate_type s);
      case (s.role)
         R_KEY: begin
            for (int k = 0; k < 3; k++)
               if (s.kpos != key_len(k)) s.cand[k] = 1'b0;
            s.phase = P_TOP_COLON;
         end
         R_OP: begin
            if (s.npos != 5'(OP_LEN)) s.nmatch = 1'b0;
            s.fields[0] = 1'b1;
            s = value_end(s);
         end
         R_HINT: begin
            s.fields[2] = 1'b1;
            s = value_end(s);
         end
         R_SKIPK: s.phase = P_SCOLON;
         default: s = value_end(s);
      endcase
      return s;
   endfunction

   // pid digit with int64 overflow check
   function automatic pstate_type accumulate(pstate_type s, logic [7:0] c);
      logic [3:0] d;
      logic [3:0] last_ok;
      d = 4'(c - "0");
      last_ok = s.pflags[0] ? 4'd8 : 4'd7;
      if (s.role != R_PID || s.pflags[1]) return s;
      if (s.mag > PID_STEP_LIMIT || (s.mag == PID_STEP_LIMIT && d > last_ok)) begin
         s.pflags[1] = 1'b1;
         s.failed = 1'b1;
      end else begin
         s.mag = (s.mag << 3) + (s.mag << 1) + 64'(d);
      end
      return s;
   endfunction

   function automatic pstate_type top_ws_key(pstate_type s, logic [7:0] c);
      if (!is_ws(c)) begin
         if (c == "\"") s = open_string(s, R_KEY);
         else s.failed = 1'b1;
      end
      return s;
   endfunction

   // one pass of the grammar over the current byte
   function automatic step_type step(step_type r, logic [7:0] c);
      logic [4:0]  h;
      logic        pid;
      logic [1:0]  li;
      logic        kind;
      pstate_type  s;
      s = r.s;
      r.redo = 1'b0;
      pid = (s.role == R_PID);
      h = hex_val(c);
      li = 2'd0;
      kind = s.stack[0];
      case (s.phase)
         P_START: begin
            if (!is_ws(c)) begin
               if (c == "{") s.phase = P_TOP_FIRST;
               else s.failed = 1'b1;
            end
         end
         P_TOP_FIRST: begin
            if (c == "}") s.failed = 1'b1;
            else s = top_ws_key(s, c);
         end
         P_TOP_KEY: s = top_ws_key(s, c);
         P_TOP_COLON: begin
            if (!is_ws(c)) begin
               if (c == ":") s.phase = P_TOP_VALUE;
               else s.failed = 1'b1;
            end
         end
         P_TOP_VALUE: begin
            if (!is_ws(c)) begin
               if (s.cand[0]) begin
                  if (s.fields[0] || c != "\"") s.failed = 1'b1;
                  else s = open_string(s, R_OP);
               end else if (s.cand[1]) begin
                  if (s.fields[1]) begin
                     s.failed = 1'b1;
                  end else begin
                     s.role = R_PID;
                     s.mag = 64'd0;
                     s.pflags = 2'd0;
                     if (c == "-") begin
                        s.pflags = 2'd1;
                        s.phase = P_NSIGN;
                     end else if (c == "0") begin
                        s.phase = P_NZERO;
                     end else if (is_digit(c)) begin
                        s.mag = 64'(c - "0");
                        s.phase = P_NDIG;
                     end else begin
                        s.failed = 1'b1;
                     end
                  end
               end else if (s.cand[2]) begin
                  if (s.fields[2] || c != "\"") s.failed = 1'b1;
                  else s = open_string(s, R_HINT);
               end else begin
                  s.phase = P_VAL;
                  r.redo = 1'b1;
               end
            end
         end
         P_TOP_AFTER: begin
            if (!is_ws(c)) begin
               if (c == "}") s.phase = P_DONE;
               else if (c == ",") s.phase = P_TOP_KEY;
               else s.failed = 1'b1;
            end
         end
         P_DONE: if (!is_ws(c)) s.failed = 1'b1;
         P_STR: begin
            if (c == "\"") s = close_string(s);
            else if (c < 8'h20) s.failed = 1'b1;
            else if (c == "\\") s.phase = P_ESC;
            else begin
               r.s = s;
               r = do_sink(r, 3'd1, {24'd0, c});
               s = r.s;
            end
         end
         P_ESC: begin
            s.phase = P_STR;
            r.s = s;
            case (c)
               "\"", "\\", "/": r = do_sink(r, 3'd1, {24'd0, c});
               "b": r = do_sink(r, 3'd1, 32'd8);
               "f": r = do_sink(r, 3'd1, 32'd12);
               "n": r = do_sink(r, 3'd1, 32'd10);
               "r": r = do_sink(r, 3'd1, 32'd13);
               "t": r = do_sink(r, 3'd1, 32'd9);
               "u": begin
                  r.s.phase = P_HEX;
                  r.s.tpos = 3'd0;
                  r.s.hex = 16'd0;
               end
               default: r.s.failed = 1'b1;
            endcase
            s = r.s;
         end
         P_HEX, P_HEXLO: begin
            if (!h[4]) begin
               s.failed = 1'b1;
            end else begin
               s.hex = {s.hex[11:0], h[3:0]};
               s.tpos = s.tpos + 3'd1;
               if (s.tpos == 3'd4) begin
                  if (s.phase == P_HEX) begin
                     if (s.hex inside {[16'hD800:16'hDBFF]}) begin
                        s.hsur = s.hex[9:0];
                        s.phase = P_BSL;
                     end else if (s.hex inside {[16'hDC00:16'hDFFF]}) begin
                        s.failed = 1'b1;
                     end else begin
                        s.phase = P_STR;
                        r.s = s;
                        r = do_emit(r, {5'd0, s.hex});
                        s = r.s;
                     end
                  end else if (s.hex inside {[16'hDC00:16'hDFFF]}) begin
                     s.phase = P_STR;
                     r.s = s;
                     r = do_emit(r, 21'h10000 + {1'b0, s.hsur, s.hex[9:0]});
                     s = r.s;
                  end else begin
                     s.failed = 1'b1;
                  end
               end
            end
         end
         P_BSL: begin
            if (c == "\\") s.phase = P_U;
            else s.failed = 1'b1;
         end
         P_U: begin
            if (c == "u") begin
               s.phase = P_HEXLO;
               s.tpos = 3'd0;
               s.hex = 16'd0;
            end else begin
               s.failed = 1'b1;
            end
         end
         P_VAL: begin
            if (!is_ws(c)) begin
               if (s.level > LW'(MAX_NEST)) begin
                  s.failed = 1'b1;
               end else begin
                  s.role = R_NUM;
                  if (c == "\"") s = open_string(s, R_SKIPV);
                  else if (c == "{") s = push(s, 1'b0, P_OOPEN);
                  else if (c == "[") s = push(s, 1'b1, P_AOPEN);
                  else if (c == "t") begin
                     s.phase = P_LIT0;
                     s.tpos = 3'd1;
                  end else if (c == "f") begin
                     s.phase = P_LIT1;
                     s.tpos = 3'd1;
                  end else if (c == "n") begin
                     s.phase = P_LIT2;
                     s.tpos = 3'd1;
                  end else if (c == "-") s.phase = P_NSIGN;
                  else if (c == "0") s.phase = P_NZERO;
                  else if (is_digit(c)) s.phase = P_NDIG;
                  else s.failed = 1'b1;
               end
            end
         end
         P_LIT0, P_LIT1, P_LIT2: begin
            li = (s.phase == P_LIT0) ? 2'd0 : (s.phase == P_LIT1) ? 2'd1 : 2'd2;
            if (lit_match(li, s.tpos, c)) begin
               s.tpos = s.tpos + 3'd1;
               if (s.tpos == lit_len(li)) s = value_end(s);
            end else begin
               s.failed = 1'b1;
            end
         end
         P_NSIGN: begin
            if (c == "0") s.phase = P_NZERO;
            else if (is_digit(c)) begin
               s = accumulate(s, c);
               s.phase = P_NDIG;
            end else s.failed = 1'b1;
         end
         P_NZERO, P_NDIG: begin
            if (is_digit(c)) begin
               if (s.phase == P_NZERO) s.failed = 1'b1;
               else s = accumulate(s, c);
            end else if (c == ".") begin
               if (pid) s.failed = 1'b1;
               else s.phase = P_FRAC1;
            end else if (c == "e" || c == "E") begin
               if (pid) s.failed = 1'b1;
               else s.phase = P_EXPS;
            end else begin
               if (pid) s.fields[1] = 1'b1;
               s = value_end(s);
               r.redo = 1'b1;
            end
         end
         P_FRAC1: begin
            if (is_digit(c)) s.phase = P_FRAC;
            else s.failed = 1'b1;
         end
         P_FRAC: begin
            if (c == "e" || c == "E") s.phase = P_EXPS;
            else if (!is_digit(c)) begin
               if (pid) s.fields[1] = 1'b1;
               s = value_end(s);
               r.redo = 1'b1;
            end
         end
         P_EXPS: begin
            if (c == "+" || c == "-") s.phase = P_EXP1;
            else if (is_digit(c)) s.phase = P_EXP;
            else s.failed = 1'b1;
         end
         P_EXP1: begin
            if (is_digit(c)) s.phase = P_EXP;
            else s.failed = 1'b1;
         end
         P_EXP: begin
            if (!is_digit(c)) begin
               if (pid) s.fields[1] = 1'b1;
               s = value_end(s);
               r.redo = 1'b1;
            end
         end
         P_OOPEN: begin
            if (!is_ws(c)) begin
               if (c == "}") s = pop_end(s);
               else if (c == "\"") s = open_string(s, R_SKIPK);
               else s.failed = 1'b1;
            end
         end
         P_AOPEN: begin
            if (!is_ws(c)) begin
               if (c == "]") s = pop_end(s);
               else begin
                  s.phase = P_VAL;
                  r.redo = 1'b1;
               end
            end
         end
         P_SAFTER: begin
            if (!is_ws(c)) begin
               if (s.level == '0) s.failed = 1'b1;
               else if ((!kind && c == "}") || (kind && c == "]")) s = pop_end(s);
               else if (c == ",") s.phase = kind ? P_VAL : P_SKEY;
               else s.failed = 1'b1;
            end
         end
         P_SKEY: begin
            if (!is_ws(c)) begin
               if (c == "\"") s = open_string(s, R_SKIPK);
               else s.failed = 1'b1;
            end
         end
         P_SCOLON: begin
            if (!is_ws(c)) begin
               if (c == ":") s.phase = P_VAL;
               else s.failed = 1'b1;
            end
         end
         default: s.failed = 1'b1;
      endcase
      r.s = s;
      return r;
   endfunction

   pstate_type state_ff, state_in;
   step_type   pass_a, pass_b, pass_done;
   status_type verdict_status;
   logic       accept;

   assign req_bus.ready = push_ready;
   assign accept = req_bus.valid && push_ready;

   // up to two grammar passes per byte: a number end, an open array or an unknown top key's value hands the byte on
   always_comb begin
      pass_a = '0;
      pass_a.s = state_ff;
      pass_b = pass_a;
      if (!state_ff.failed) begin
         pass_a = step(pass_a, req_bus.in_byte);
         pass_b = pass_a;
         if (pass_a.redo && !pass_a.s.failed) pass_b = step(pass_a, req_bus.in_byte);
      end
      pass_done = pass_b;
   end

   // verdict from the state after this byte
   always_comb begin
      if (pass_done.s.failed || pass_done.s.phase != P_DONE || pass_done.s.fields[1:0] != 2'b11)
         verdict_status = ST_INVALID;
      else if (!pass_done.s.nmatch)
         verdict_status = ST_UNSUPPORTED;
      else if (pass_done.s.pflags[0] || pass_done.s.mag == 64'd0 || pass_done.s.mag > PID_MAX)
         verdict_status = ST_BAD_PID;
      else
         verdict_status = ST_OK;
   end

   always_comb begin
      push_entry.cnt = pass_done.cnt;
      push_entry.bytes = pass_done.bytes;
      push_entry.verdict = req_bus.is_final;
      push_entry.status = verdict_status;
      push_entry.pid = (verdict_status == ST_OK) ? pass_done.s.mag[30:0] : 31'd0;
      push_valid = req_bus.valid && (pass_done.cnt != 3'd0 || req_bus.is_final);
      state_in = req_bus.is_final ? reset_state() : pass_done.s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/jrsv_queue.sv =====
module jrsv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  jrsv_pkg::qentry_type push_entry,
   output logic                 head_valid,
   input  logic                 pop,
   output jrsv_pkg::qentry_type head_entry
);
   import jrsv_pkg::*;

   localparam int PW = $clog2(Q_DEPTH);

   qentry_type     mem_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]    count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != (PW+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== sv/jrsv_back.sv =====
module jrsv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  jrsv_pkg::qentry_type head_entry,
   output logic                 pop,
   jrsv_rsp_if.source           rsp_bus
);
   import jrsv_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       last;
   logic       is_verdict;
   logic       take;

   assign total = head_entry.cnt + {2'b00, head_entry.verdict};
   assign last = (idx_ff == total - 3'd1);
   assign is_verdict = (idx_ff >= head_entry.cnt);
   assign take = rsp_bus.valid && rsp_bus.ready;
   assign pop = take && last;

   // result fields for the current position within the head entry
   always_comb begin
      rsp_bus.valid = head_valid;
      rsp_bus.kind = is_verdict;
      rsp_bus.hint_byte = is_verdict ? 8'd0 : head_entry.bytes[8*idx_ff[1:0] +: 8];
      rsp_bus.status = is_verdict ? head_entry.status : ST_OK;
      rsp_bus.pid_value = is_verdict ? head_entry.pid : 31'd0;
      rsp_bus.run_end = last;
   end

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = last ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
